// ===== rtl/skts_pkg.sv =====
package skts_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned PosW       = 6;
  localparam int unsigned TotalW     = 7;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_FOUND     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [KeyW-1:0]  wr_data;
  } mem_req_t;

  // gt: search key above table entry
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

endpackage

// ===== rtl/skts_chan_if.sv =====
interface skts_req_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic signed [skts_pkg::KeyW-1:0] key;

  modport source (output valid, action, key, input ready);
  modport sink   (input valid, action, key, output ready);
endinterface

interface skts_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [skts_pkg::StatusW-1:0] status;
  logic [skts_pkg::PosW-1:0]    position;
  logic [skts_pkg::TotalW-1:0]  entry_total;

  modport source (output valid, status, position, entry_total, input ready);
  modport sink   (input valid, status, position, entry_total, output ready);
endinterface

// ===== rtl/skts_ram.sv =====
module skts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/skts_cmp.sv =====
module skts_cmp (
  input  logic signed [skts_pkg::KeyW-1:0] key_i,
  input  logic        [skts_pkg::KeyW-1:0] entry_i,
  output skts_pkg::cmp_t                   cmp_o
);

  logic signed [skts_pkg::KeyW-1:0] entry_s;

  assign entry_s   = $signed(entry_i);
  assign cmp_o.eq  = (key_i == entry_s);
  assign cmp_o.gt  = (key_i > entry_s);

endmodule

// ===== rtl/skts_seq.sv =====
module skts_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  logic                             req_action_i,
  input  logic signed [skts_pkg::KeyW-1:0] req_key_i,
  output logic                             rsp_valid_o,
  input  logic                             rsp_ready_i,
  output logic [skts_pkg::StatusW-1:0]     rsp_status_o,
  output logic [skts_pkg::PosW-1:0]        rsp_position_o,
  output logic [skts_pkg::TotalW-1:0]      rsp_total_o,
  output skts_pkg::mem_req_t               mem_req_o,
  input  logic [skts_pkg::KeyW-1:0]        mem_rdata_i
);

  skts_pkg::state_e                 state_q, state_d;
  logic                             act_q, act_d;
  logic signed [skts_pkg::KeyW-1:0] key_q, key_d;
  logic [skts_pkg::CntW-1:0]        lo_q, lo_d;
  logic [skts_pkg::CntW-1:0]        he_q, he_d;
  logic [skts_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic [skts_pkg::AddrW-1:0]       ptr_q, ptr_d;
  logic [skts_pkg::AddrW-1:0]       waddr_q, waddr_d;
  logic                             wpend_q, wpend_d;
  skts_pkg::status_e                res_st_q, res_st_d;
  logic [skts_pkg::AddrW-1:0]       res_pos_q, res_pos_d;
  logic                             out_valid_q, out_valid_d;
  logic [skts_pkg::StatusW-1:0]     out_st_q, out_st_d;
  logic [skts_pkg::PosW-1:0]        out_pos_q, out_pos_d;
  logic [skts_pkg::TotalW-1:0]      out_tot_q, out_tot_d;

  logic [skts_pkg::CntW:0]          mid_sum;
  logic [skts_pkg::AddrW-1:0]       mid;
  logic [skts_pkg::CntW-1:0]        mid_cnt;
  logic                             out_free;
  logic                             full;
  skts_pkg::cmp_t                   cmp;

  skts_cmp u_cmp (
    .key_i   (key_q),
    .entry_i (mem_rdata_i),
    .cmp_o   (cmp)
  );

  // probe = floor((lo + hi) / 2) with hi = he - 1
  assign mid_sum  = {1'b0, lo_q} + {1'b0, he_q} - (skts_pkg::CntW + 1)'(1);
  assign mid      = mid_sum[skts_pkg::AddrW:1];
  assign mid_cnt  = {1'b0, mid};
  assign out_free = !out_valid_q || rsp_ready_i;
  assign full     = (cnt_q == skts_pkg::CntW'(skts_pkg::TableDepth));

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    key_d       = key_q;
    lo_d        = lo_q;
    he_d        = he_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    waddr_d     = waddr_q;
    wpend_d     = wpend_q;
    res_st_d    = res_st_q;
    res_pos_d   = res_pos_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_pos_d   = out_pos_q;
    out_tot_d   = out_tot_q;
    req_ready_o = 1'b0;
    mem_req_o   = '0;

    if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      skts_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          act_d = req_action_i;
          key_d = req_key_i;
          lo_d  = '0;
          he_d  = cnt_q;
          if (req_action_i == skts_pkg::ACT_INSERT && full) begin
            res_st_d  = skts_pkg::STAT_FULL;
            res_pos_d = '0;
            state_d   = skts_pkg::S_DONE;
          end else begin
            state_d = skts_pkg::S_PROBE;
          end
        end
      end
      skts_pkg::S_PROBE: begin
        if (lo_q < he_q) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = mid;
          state_d           = skts_pkg::S_CMP;
        end else if (act_q == skts_pkg::ACT_LOOKUP) begin
          res_st_d  = skts_pkg::STAT_NOT_FOUND;
          res_pos_d = '0;
          state_d   = skts_pkg::S_DONE;
        end else begin
          ptr_d   = cnt_q[skts_pkg::AddrW-1:0];
          wpend_d = 1'b0;
          state_d = skts_pkg::S_SHIFT;
        end
      end
      skts_pkg::S_CMP: begin
        if (act_q == skts_pkg::ACT_LOOKUP && cmp.eq) begin
          res_st_d  = skts_pkg::STAT_FOUND;
          res_pos_d = mid;
          state_d   = skts_pkg::S_DONE;
        end else begin
          if (cmp.gt || (act_q == skts_pkg::ACT_INSERT && cmp.eq)) begin
            lo_d = mid_cnt + skts_pkg::CntW'(1);
          end else begin
            he_d = mid_cnt;
          end
          state_d = skts_pkg::S_PROBE;
        end
      end
      skts_pkg::S_SHIFT: begin
        // read entry ptr-1 while the previous read lands one slot up
        if (wpend_q) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = waddr_q;
          mem_req_o.wr_data = mem_rdata_i;
        end
        if ({1'b0, ptr_q} > lo_q) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = ptr_q - skts_pkg::AddrW'(1);
          wpend_d           = 1'b1;
          waddr_d           = ptr_q;
          ptr_d             = ptr_q - skts_pkg::AddrW'(1);
        end else begin
          wpend_d = 1'b0;
          state_d = skts_pkg::S_PLACE;
        end
      end
      skts_pkg::S_PLACE: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = lo_q[skts_pkg::AddrW-1:0];
        mem_req_o.wr_data = key_q;
        cnt_d             = cnt_q + skts_pkg::CntW'(1);
        res_st_d          = skts_pkg::STAT_INSERTED;
        res_pos_d         = lo_q[skts_pkg::AddrW-1:0];
        state_d           = skts_pkg::S_DONE;
      end
      skts_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_pos_d   = skts_pkg::PosW'(res_pos_q);
          out_tot_d   = skts_pkg::TotalW'(cnt_q);
          state_d     = skts_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = skts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skts_pkg::S_IDLE;
      cnt_q       <= '0;
      wpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wpend_q     <= wpend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    key_q     <= key_d;
    lo_q      <= lo_d;
    he_q      <= he_d;
    ptr_q     <= ptr_d;
    waddr_q   <= waddr_d;
    res_st_q  <= res_st_d;
    res_pos_q <= res_pos_d;
    out_st_q  <= out_st_d;
    out_pos_q <= out_pos_d;
    out_tot_q <= out_tot_d;
  end

  assign rsp_valid_o    = out_valid_q;
  assign rsp_status_o   = out_st_q;
  assign rsp_position_o = out_pos_q;
  assign rsp_total_o    = out_tot_q;

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= skts_pkg::CntW'(skts_pkg::TableDepth))
    else $error("key count above table depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + skts_pkg::CntW'(1)))
    else $error("key count moved by other than one");

  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.rd_en |-> ({1'b0, mem_req_o.rd_addr} < cnt_q))
    else $error("read of an entry not yet written");

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> ({1'b0, mem_req_o.wr_addr} <= cnt_q))
    else $error("write beyond end of table");

  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skts_pkg::S_DONE && out_free) |=> out_valid_q)
    else $error("finished item not presented");

endmodule

// ===== rtl/sorted_key_table_search_unit.sv =====
// channel  dir  handshake      payload
// req_i    in   valid / ready  action, key
// rsp_o    out  valid / ready  status, position, entry_total
//
// Lookup: at most log2(depth)+1 probes, each a RAM read in S_PROBE and a compare in S_CMP.
// Insert: the same probes, then every entry from the slot up moves one place, since the one
// RAM port pair reads and writes one key a cycle, then S_PLACE writes the new key.
// Insert into a full table goes straight to S_DONE. Reset clears the key count; no clearing pass.
// A result waits in the output register while the next item is taken.
module sorted_key_table_search_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  skts_req_if.sink    req_i,
  skts_rsp_if.source  rsp_o
);

  skts_pkg::mem_req_t              mem_req;
  logic [skts_pkg::KeyW-1:0]       mem_rdata;

  skts_ram #(
    .Width (skts_pkg::KeyW),
    .Depth (skts_pkg::TableDepth)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mem_req.wr_en),
    .wr_addr_i (mem_req.wr_addr),
    .wr_data_i (mem_req.wr_data),
    .rd_en_i   (mem_req.rd_en),
    .rd_addr_i (mem_req.rd_addr),
    .rd_data_o (mem_rdata)
  );

  skts_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_i.valid),
    .req_ready_o    (req_i.ready),
    .req_action_i   (req_i.action),
    .req_key_i      (req_i.key),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_status_o   (rsp_o.status),
    .rsp_position_o (rsp_o.position),
    .rsp_total_o    (rsp_o.entry_total),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata)
  );

endmodule

// ===== sim/skts_search_checker.sv =====
`timescale 1ns / 1ps

module skts_search_checker
  import skts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  skts_req_if         req_mon,
  skts_rsp_if         rsp_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    status_e           status;
    logic [PosW-1:0]   position;
    logic [TotalW-1:0] entry_total;
  } search_result_t;

  logic signed [KeyW-1:0] sorted_keys [TableDepth];
  int                     key_total;
  search_result_t         expected_results_q [$];
  search_result_t         oldest;

  // Mirrors the table: ordered insert after equal keys, then floor-midpoint search.
  function automatic search_result_t predict_search_result(logic act,
                                                           logic signed [KeyW-1:0] k);
    search_result_t res;
    int             slot;
    int             lo;
    int             hi;
    int             mid;
    bit             hit;
    res.status   = STAT_NOT_FOUND;
    res.position = '0;
    hit          = 1'b0;
    if (act == ACT_INSERT) begin
      if (key_total >= TableDepth) begin
        res.status = STAT_FULL;
      end else begin
        slot = 0;
        while (slot < key_total && sorted_keys[slot] <= k) slot++;
        for (int i = key_total; i > slot; i--) sorted_keys[i] = sorted_keys[i-1];
        sorted_keys[slot] = k;
        key_total++;
        res.status   = STAT_INSERTED;
        res.position = PosW'(slot);
      end
    end else begin
      lo = 0;
      hi = key_total - 1;
      while (!hit && lo <= hi) begin
        mid = (lo + hi) / 2;
        if (sorted_keys[mid] == k) begin
          hit          = 1'b1;
          res.status   = STAT_FOUND;
          res.position = PosW'(mid);
        end else if (k > sorted_keys[mid]) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    res.entry_total = TotalW'(key_total);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_total    = 0;
      fail_count_o = 0;
      expected_results_q.delete();
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        expected_results_q.push_back(predict_search_result(req_mon.action, req_mon.key));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_results_q.size() == 0) begin
          $error("unexpected result: status %0d position %0d entry_total %0d",
                 rsp_mon.status, rsp_mon.position, rsp_mon.entry_total);
          fail_count_o++;
        end else begin
          oldest = expected_results_q.pop_front();
          if (rsp_mon.status !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, rsp_mon.status);
            fail_count_o++;
          end
          if (rsp_mon.position !== oldest.position) begin
            $error("position: expected %0d, actual %0d", oldest.position, rsp_mon.position);
            fail_count_o++;
          end
          if (rsp_mon.entry_total !== oldest.entry_total) begin
            $error("entry_total: expected %0d, actual %0d",
                   oldest.entry_total, rsp_mon.entry_total);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_results_q.size();
  end

endmodule

// ===== sim/tb_sorted_key_table_search_unit.sv =====
`timescale 1ns / 1ps

module tb_sorted_key_table_search_unit;
  import skts_pkg::*;

  localparam int unsigned RandItems   = 630;
  localparam int unsigned PhaseLen    = 158;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned CycleLimit  = 400000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  skts_req_if req_if ();
  skts_rsp_if rsp_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned cycle_count   = 0;
  int unsigned insert_count  = 0;
  int unsigned lookup_count  = 0;
  int unsigned reject_count  = 0;

  logic signed [KeyW-1:0] held_keys [$];

  sorted_key_table_search_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  skts_search_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Holds valid until the item is taken; the next call decides whether valid drops.
  task automatic send_item(input logic act, input logic signed [KeyW-1:0] k);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.key    <= k;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (act == ACT_INSERT) begin
      insert_count++;
      if (held_keys.size() < TableDepth) held_keys.push_back(k);
      else reject_count++;
    end else begin
      lookup_count++;
    end
  endtask

  function automatic logic signed [KeyW-1:0] pick_corner_key();
    case ($urandom_range(0, 4))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return -32'sd1;
      3:       return 32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic logic signed [KeyW-1:0] pick_held_key();
    return held_keys[$urandom_range(0, held_keys.size() - 1)];
  endfunction

  // Small range keeps duplicates common.
  function automatic logic signed [KeyW-1:0] pick_insert_key();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return pick_corner_key();
    if (sel < 4) return $signed(KeyW'($urandom_range(0, 40))) - 32'sd20;
    if (sel == 4 && held_keys.size() != 0) return pick_held_key() + 32'sd2;
    return $signed(KeyW'($urandom));
  endfunction

  function automatic logic signed [KeyW-1:0] pick_lookup_key();
    int unsigned sel;
    sel = $urandom_range(0, 3);
    if (held_keys.size() == 0 || sel == 3) return pick_insert_key();
    if (sel == 2) return pick_held_key() + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
    return pick_held_key();
  endfunction

  initial begin
    bit do_insert;
    req_if.valid  = 1'b0;
    req_if.action = ACT_INSERT;
    req_if.key    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, corners, duplicates, misses next to hits
    send_item(ACT_LOOKUP, 32'sd0);
    send_item(ACT_INSERT, 32'sd0);
    send_item(ACT_LOOKUP, 32'sd0);
    send_item(ACT_LOOKUP, 32'sd5);
    send_item(ACT_INSERT, 32'sh7FFF_FFFF);
    send_item(ACT_INSERT, 32'sh8000_0000);
    send_item(ACT_INSERT, -32'sd1);
    send_item(ACT_INSERT, 32'sd1);
    send_item(ACT_INSERT, 32'sd0);
    send_item(ACT_INSERT, 32'sd0);
    send_item(ACT_INSERT, 32'sh8000_0000);
    send_item(ACT_INSERT, 32'sh7FFF_FFFF);
    send_item(ACT_LOOKUP, 32'sh8000_0000);
    send_item(ACT_LOOKUP, 32'sh7FFF_FFFF);
    send_item(ACT_LOOKUP, -32'sd1);
    send_item(ACT_LOOKUP, 32'sd1);
    send_item(ACT_LOOKUP, 32'sd0);
    send_item(ACT_LOOKUP, -32'sd2);
    send_item(ACT_LOOKUP, 32'sd2);
    send_item(ACT_LOOKUP, 32'sh7FFF_FFFE);
    send_item(ACT_LOOKUP, 32'sh8000_0001);
    send_item(ACT_INSERT, 32'sh5555_5555);
    send_item(ACT_INSERT, 32'shAAAA_AAAA);
    send_item(ACT_LOOKUP, 32'shAAAA_AAAA);

    for (int n = 0; n < RandItems; n++) begin
      if (n % PhaseLen == 0) begin
        if (n != 0) begin
          req_if.valid <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        case (n / PhaseLen)
          0: begin
            send_idle_pct = 0;
            stall_pct     = 0;
          end
          1: begin
            send_idle_pct = 48;
            stall_pct     = 0;
          end
          2: begin
            send_idle_pct = 0;
            stall_pct     = 48;
          end
          default: begin
            send_idle_pct = 28;
            stall_pct     = 28;
          end
        endcase
      end
      // late inserts make sure the table fills and full rejects are seen
      do_insert = ($urandom_range(0, 7) == 0) ||
                  (held_keys.size() < TableDepth && RandItems - n <= 200);
      if (do_insert) send_item(ACT_INSERT, pick_insert_key());
      else send_item(ACT_LOOKUP, pick_lookup_key());
    end
    req_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d inserts (%0d rejected on a full table) and %0d lookups,",
             insert_count, reject_count, lookup_count);
    $display("across no idling, sender gaps, receiver stalls and both; %0d mismatches.",
             fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/skts_pkg.sv
rtl/skts_chan_if.sv
rtl/skts_ram.sv
rtl/skts_cmp.sv
rtl/skts_seq.sv
rtl/sorted_key_table_search_unit.sv
sim/skts_search_checker.sv
sim/tb_sorted_key_table_search_unit.sv
